>>> rtl/core/wlr_pkg.sv
// Package for the windowed linear regression unit: types, codes and constants.
package wlr_pkg;

    localparam int NUM_FACTORS_DEF = 4;
    localparam int WINDOW_MAX_DEF  = 1024;

    localparam int SAMPLE_W = 16;
    localparam int WIDE_W   = 128;
    localparam int DATA_W   = 64;

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW_START   = 2'd0;
    localparam logic [1:0] CFG_WINDOW_SIZE    = 2'd1;
    localparam logic [1:0] CFG_ACTIVE_FACTORS = 2'd2;

    localparam logic [15:0] WINDOW_START_RST   = 16'd0;
    localparam logic [10:0] WINDOW_SIZE_RST    = 11'd1024;
    localparam logic [2:0]  ACTIVE_FACTORS_RST = 3'd4;

    // search limits
    localparam logic [16:0] LIM_STD = 17'd65535;
    localparam logic [16:0] LIM_Q16 = 17'd65536;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MAC,
        S_PRD,
        S_PMUL,
        S_PSQ,
        S_PACC,
        S_DIV,
        S_MUL,
        S_SR_STEP,
        S_SR_CMP,
        S_SR_NEXT,
        S_F_INIT,
        S_F_NXX,
        S_F_SXX,
        S_F_NXY,
        S_F_SXY,
        S_F_PROD,
        S_F_C2,
        S_F_KM,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        K_YSTD,
        K_RSE,
        K_R2,
        K_CORR
    } t_srch;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_CONST_Y = 2'd1,
        ST_CONST_X = 2'd2
    } t_status;

endpackage

>>> rtl/core/wlr_ram.sv
// Generic simple dual-port RAM with registered read.
module wlr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/windowed_linear_regression_unit.sv
// Windowed least-squares line fit of y against up to four x series.
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ------------------------------------------
//  cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//  in        in         i_in_valid/o_in_stall   i_y_sample, i_x_sample_0..3
//  out       out        o_out_valid/i_out_stall factor index, std devs, r^2, r, status, last
//
// A skipped item is only counted; for a stored item the sums of x*y and x*x go through
// one 16x16 multiplier. The item that fills the window starts the fit: a second pass
// over the stored samples, a restoring divide by n, then per factor the shift-add
// multiplier (one bit of the narrow operand per cycle) inside bit-by-bit root searches.
// Reset is synchronous, active low; it clears counters, sums and configuration. The
// y store needs no clearing: only entries written in the current window are read.
// A stalled result sits in the output register while the next factor is worked on.
module windowed_linear_regression_unit
    import wlr_pkg::*;
#(
    parameter int NUM_FACTORS = NUM_FACTORS_DEF,
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [15:0]                i_cfg_data,
    // input items
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_y_sample,
    input  logic signed [SAMPLE_W-1:0] i_x_sample_0,
    input  logic signed [SAMPLE_W-1:0] i_x_sample_1,
    input  logic signed [SAMPLE_W-1:0] i_x_sample_2,
    input  logic signed [SAMPLE_W-1:0] i_x_sample_3,
    // results
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_factor_index,
    output logic [15:0]                o_y_std_dev,
    output logic [15:0]                o_residual_std_error,
    output logic [16:0]                o_r_squared,
    output logic [16:0]                o_correlation,
    output logic [1:0]                 o_fit_status,
    output logic                       o_last_result
);

    // only the first four factors can carry non-zero x and be reported
    localparam int NF     = (NUM_FACTORS < 4) ? NUM_FACTORS : 4;
    localparam int NF_W   = (NF > 1) ? $clog2(NF) : 1;
    localparam int FW     = $clog2(WINDOW_MAX + 1);   // fill count, holds WINDOW_MAX
    localparam int AW     = $clog2(WINDOW_MAX);       // store address
    localparam int CW     = (FW > 11) ? FW : 11;
    localparam int SY_W   = SAMPLE_W + FW;            // sum of samples
    localparam int SXY_W  = 2 * SAMPLE_W + FW;        // sum of products
    localparam int NY_W   = FW + 1 + SAMPLE_W;        // n * y
    localparam int D_W    = NY_W + 1;                 // n * y - sum y
    localparam int KN_W   = 2 * FW;

    // ---------------------------------------------------------------- registers
    t_state r_state, n_state;
    t_state r_ret,   n_ret;

    logic [15:0] r_window_start;
    logic [10:0] r_window_size;
    logic [2:0]  r_active_factors;

    logic [16:0]             r_item_cnt, n_item_cnt;
    logic [FW-1:0]           r_fill,     n_fill;
    logic signed [SY_W-1:0]  r_sum_y,    n_sum_y;
    logic signed [SY_W-1:0]  r_sum_x  [NF];
    logic signed [SY_W-1:0]  n_sum_x  [NF];
    logic signed [SXY_W-1:0] r_sum_xy [NF];
    logic signed [SXY_W-1:0] n_sum_xy [NF];
    logic signed [SXY_W-1:0] r_sum_xx [NF];
    logic signed [SXY_W-1:0] n_sum_xx [NF];

    logic signed [SAMPLE_W-1:0] r_y, n_y;
    logic signed [SAMPLE_W-1:0] r_x [NF];
    logic signed [SAMPLE_W-1:0] n_x [NF];
    logic [NF_W-1:0]            r_mf,  n_mf;
    logic                       r_mph, n_mph;

    logic [FW-1:0]          r_n,    n_n;
    logic [FW-1:0]          r_pi,   n_pi;
    logic signed [NY_W-1:0] r_ny,   n_ny;
    logic [DATA_W-1:0]      r_sq,   n_sq;
    logic [DATA_W-1:0]      r_ssd,  n_ssd;
    logic [DATA_W-1:0]      r_dq,   n_dq;
    logic [FW-1:0]          r_drem, n_drem;
    logic [5:0]             r_dcnt, n_dcnt;
    logic [DATA_W-1:0]      r_a,    n_a;
    logic [KN_W-1:0]        r_kn1,  n_kn1;
    logic [KN_W-1:0]        r_kn2,  n_kn2;

    logic [1:0]               r_fi,   n_fi;
    logic signed [DATA_W-1:0] r_t1,   n_t1;
    logic [DATA_W-1:0]        r_cxx,  n_cxx;
    logic [DATA_W-1:0]        r_mag,  n_mag;
    logic [WIDE_W-1:0]        r_prod, n_prod;
    logic [WIDE_W-1:0]        r_c2,   n_c2;

    // shared shift-add multiplier
    logic [WIDE_W-1:0] r_ma,  n_ma;
    logic [DATA_W-1:0] r_mb,  n_mb;
    logic [WIDE_W-1:0] r_acc, n_acc;

    // bit-by-bit search
    t_srch             r_kind, n_kind;
    logic [16:0]       r_s,    n_s;
    logic [4:0]        r_bit,  n_bit;
    logic [WIDE_W-1:0] r_sm,   n_sm;
    logic [WIDE_W-1:0] r_rhs,  n_rhs;
    logic [16:0]       r_lim,  n_lim;

    logic [15:0] r_ystd, n_ystd;
    logic [15:0] r_rse,  n_rse;
    logic [16:0] r_r2,   n_r2;
    logic [16:0] r_corr, n_corr;
    t_status     r_status, n_status;

    // output register
    logic        r_ov,       n_ov;
    logic [1:0]  r_o_fi,     n_o_fi;
    logic [15:0] r_o_ystd,   n_o_ystd;
    logic [15:0] r_o_rse,    n_o_rse;
    logic [16:0] r_o_r2,     n_o_r2;
    logic [16:0] r_o_corr,   n_o_corr;
    t_status     r_o_status, n_o_status;
    logic        r_o_last,   n_o_last;

    // ---------------------------------------------------------------- datapath wires
    logic signed [SAMPLE_W-1:0] x_in [4];
    logic                       in_acc;
    logic                       skip;
    logic [CW-1:0]              wsz;
    logic [CW-1:0]              n_eff;
    logic [2:0]                 nf_c;
    logic                       is_last;
    logic [NF_W-1:0]            fidx;
    logic signed [SY_W-1:0]     cur_sx;
    logic signed [SXY_W-1:0]    cur_sxy;
    logic signed [SXY_W-1:0]    cur_sxx;
    logic [SY_W-1:0]            abs_sx;
    logic [SY_W-1:0]            abs_sy;
    logic [SXY_W-1:0]           abs_sxy;
    logic signed [SAMPLE_W-1:0] mac_x;
    logic signed [2*SAMPLE_W-1:0] mac_p;
    logic signed [SAMPLE_W-1:0] ram_y;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [NY_W-1:0]     ny_c;
    logic signed [D_W-1:0]      d_c;
    logic signed [2*D_W-1:0]    sq_c;
    logic [FW:0]                rem2;
    logic                       rem_ge;
    logic [DATA_W-1:0]          q_next;
    logic [KN_W-1:0]            kn1_c;
    logic [KN_W-1:0]            kn2_c;
    logic [DATA_W-1:0]          cxx_c;
    logic signed [DATA_W-1:0]   t2_c;
    logic signed [DATA_W-1:0]   cxy_c;
    logic [16:0]                c_cand;
    logic [33:0]                c_sq;

    assign x_in[0] = i_x_sample_0;
    assign x_in[1] = i_x_sample_1;
    assign x_in[2] = i_x_sample_2;
    assign x_in[3] = i_x_sample_3;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign skip        = (r_fill == '0) && (r_item_cnt < {1'b0, r_window_start});

    // window length clamped to 3..WINDOW_MAX
    assign wsz   = CW'(r_window_size);
    assign n_eff = (wsz < CW'(3)) ? CW'(3) :
                   (wsz > CW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : wsz;

    // reported factors clamped to 1..NF
    assign nf_c    = (r_active_factors > 3'(NF)) ? 3'(NF) :
                     (r_active_factors == 3'd0) ? 3'd1 : r_active_factors;
    assign is_last = (({1'b0, r_fi} + 3'd1) == nf_c);

    assign fidx    = NF_W'(r_fi);
    assign cur_sx  = r_sum_x[fidx];
    assign cur_sxy = r_sum_xy[fidx];
    assign cur_sxx = r_sum_xx[fidx];
    assign abs_sx  = cur_sx[SY_W-1]   ? SY_W'(-cur_sx)   : SY_W'(cur_sx);
    assign abs_sy  = r_sum_y[SY_W-1]  ? SY_W'(-r_sum_y)  : SY_W'(r_sum_y);
    assign abs_sxy = cur_sxy[SXY_W-1] ? SXY_W'(-cur_sxy) : SXY_W'(cur_sxy);

    // accumulate phase: one 16x16 product per cycle
    assign mac_x = r_x[r_mf];
    assign mac_p = mac_x * (r_mph ? mac_x : r_y);

    // second pass over the stored y samples
    assign ram_y = $signed(ram_rdata);
    assign ny_c  = $signed({1'b0, r_n}) * ram_y;
    assign d_c   = D_W'(r_ny) - D_W'(r_sum_y);
    assign sq_c  = d_c * d_c;

    // restoring divide by n, one quotient bit a cycle
    assign rem2   = {r_drem, r_dq[DATA_W-1]};
    assign rem_ge = (rem2 >= {1'b0, r_n});
    assign q_next = {r_dq[DATA_W-2:0], rem_ge};

    assign kn1_c = r_fill * (r_fill - FW'(1));
    assign kn2_c = r_fill * (r_fill - FW'(2));

    assign cxx_c = r_t1 - r_acc[DATA_W-1:0];
    assign t2_c  = (cur_sx[SY_W-1] ^ r_sum_y[SY_W-1]) ? -$signed(r_acc[DATA_W-1:0])
                                                       :  $signed(r_acc[DATA_W-1:0]);
    assign cxy_c = r_t1 - t2_c;

    assign c_cand = r_s | (17'd1 << r_bit);
    assign c_sq   = c_cand * c_cand;

    wlr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_y_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && !skip),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_y_sample),
        .i_raddr (r_pi[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_item_cnt = r_item_cnt;
        n_fill     = r_fill;
        n_sum_y    = r_sum_y;
        n_sum_x    = r_sum_x;
        n_sum_xy   = r_sum_xy;
        n_sum_xx   = r_sum_xx;
        n_y        = r_y;
        n_x        = r_x;
        n_mf       = r_mf;
        n_mph      = r_mph;
        n_n        = r_n;
        n_pi       = r_pi;
        n_ny       = r_ny;
        n_sq       = r_sq;
        n_ssd      = r_ssd;
        n_dq       = r_dq;
        n_drem     = r_drem;
        n_dcnt     = r_dcnt;
        n_a        = r_a;
        n_kn1      = r_kn1;
        n_kn2      = r_kn2;
        n_fi       = r_fi;
        n_t1       = r_t1;
        n_cxx      = r_cxx;
        n_mag      = r_mag;
        n_prod     = r_prod;
        n_c2       = r_c2;
        n_ma       = r_ma;
        n_mb       = r_mb;
        n_acc      = r_acc;
        n_kind     = r_kind;
        n_s        = r_s;
        n_bit      = r_bit;
        n_sm       = r_sm;
        n_rhs      = r_rhs;
        n_lim      = r_lim;
        n_ystd     = r_ystd;
        n_rse      = r_rse;
        n_r2       = r_r2;
        n_corr     = r_corr;
        n_status   = r_status;
        n_ov       = r_ov && i_out_stall;
        n_o_fi     = r_o_fi;
        n_o_ystd   = r_o_ystd;
        n_o_rse    = r_o_rse;
        n_o_r2     = r_o_r2;
        n_o_corr   = r_o_corr;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (skip) begin
                        n_item_cnt = r_item_cnt + 17'd1;
                    end else begin
                        n_y     = i_y_sample;
                        n_sum_y = r_sum_y + SY_W'(i_y_sample);
                        for (int f = 0; f < NF; f++) begin
                            n_x[f]     = x_in[f];
                            n_sum_x[f] = r_sum_x[f] + SY_W'(x_in[f]);
                        end
                        n_fill  = r_fill + FW'(1);
                        n_mf    = '0;
                        n_mph   = 1'b0;
                        n_state = S_MAC;
                    end
                end
            end

            S_MAC: begin
                if (r_mph) begin
                    n_sum_xx[r_mf] = r_sum_xx[r_mf] + SXY_W'(mac_p);
                end else begin
                    n_sum_xy[r_mf] = r_sum_xy[r_mf] + SXY_W'(mac_p);
                end
                n_mph = !r_mph;
                if (r_mph) begin
                    n_mf = r_mf + NF_W'(1);
                end
                if (r_mph && (r_mf == NF_W'(NF - 1))) begin
                    if (CW'(r_fill) >= n_eff) begin
                        // window closes: second pass starts at entry 0
                        n_n     = r_fill;
                        n_pi    = '0;
                        n_ssd   = '0;
                        n_kn1   = kn1_c;
                        n_kn2   = kn2_c;
                        n_state = S_PRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_PRD: begin
                n_state = S_PMUL;
            end

            S_PMUL: begin
                n_ny    = ny_c;
                n_state = S_PSQ;
            end

            S_PSQ: begin
                n_sq    = DATA_W'(sq_c);
                n_state = S_PACC;
            end

            S_PACC: begin
                n_ssd = r_ssd + r_sq;
                n_pi  = r_pi + FW'(1);
                if ((r_pi + FW'(1)) == r_n) begin
                    n_dq    = r_ssd + r_sq;
                    n_drem  = '0;
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_PRD;
                end
            end

            S_DIV: begin
                n_drem = rem_ge ? FW'(rem2 - {1'b0, r_n}) : FW'(rem2);
                n_dq   = q_next;
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'd63) begin
                    n_a  = q_next;
                    n_fi = '0;
                    if (q_next == '0) begin
                        n_state = S_F_INIT;
                    end else begin
                        n_kind  = K_YSTD;
                        n_s     = '0;
                        n_bit   = 5'd16;
                        n_sm    = WIDE_W'(r_kn1);
                        n_rhs   = WIDE_W'(q_next);
                        n_lim   = LIM_STD;
                        n_state = S_SR_STEP;
                    end
                end
            end

            S_MUL: begin
                if (r_mb == '0) begin
                    n_state = r_ret;
                end else begin
                    if (r_mb[0]) begin
                        n_acc = r_acc + r_ma;
                    end
                    n_ma = r_ma << 1;
                    n_mb = r_mb >> 1;
                end
            end

            S_SR_STEP: begin
                if (c_cand > r_lim) begin
                    n_state = S_SR_NEXT;
                end else begin
                    n_ma    = r_sm;
                    n_mb    = (r_kind == K_R2) ? DATA_W'(c_cand) : DATA_W'(c_sq);
                    n_acc   = '0;
                    n_ret   = S_SR_CMP;
                    n_state = S_MUL;
                end
            end

            S_SR_CMP: begin
                if (r_acc <= r_rhs) begin
                    n_s = c_cand;
                end
                n_state = S_SR_NEXT;
            end

            S_SR_NEXT: begin
                if (r_bit != 5'd0) begin
                    n_bit   = r_bit - 5'd1;
                    n_state = S_SR_STEP;
                end else begin
                    n_s   = '0;
                    n_bit = 5'd16;
                    n_lim = LIM_Q16;
                    case (r_kind)
                        K_YSTD: begin
                            n_ystd  = r_s[15:0];
                            n_state = S_F_INIT;
                        end
                        K_RSE: begin
                            n_rse = r_s[15:0];
                            if (r_status == ST_CONST_X) begin
                                n_state = S_OUT;
                            end else begin
                                n_kind  = K_R2;
                                n_sm    = r_prod;
                                n_rhs   = r_c2 << 16;
                                n_state = S_SR_STEP;
                            end
                        end
                        K_R2: begin
                            n_r2    = r_s;
                            n_kind  = K_CORR;
                            n_sm    = WIDE_W'(1);
                            n_rhs   = WIDE_W'(r_s) << 16;
                            n_state = S_SR_STEP;
                        end
                        default: begin
                            n_corr  = r_s;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            S_F_INIT: begin
                if (r_a == '0) begin
                    n_status = ST_CONST_Y;
                    n_state  = S_OUT;
                end else begin
                    // n * sum xx
                    n_ma    = WIDE_W'(SXY_W'(cur_sxx));
                    n_mb    = DATA_W'(r_n);
                    n_acc   = '0;
                    n_ret   = S_F_NXX;
                    n_state = S_MUL;
                end
            end

            S_F_NXX: begin
                n_t1    = $signed(r_acc[DATA_W-1:0]);
                n_ma    = WIDE_W'(abs_sx);
                n_mb    = DATA_W'(abs_sx);
                n_acc   = '0;
                n_ret   = S_F_SXX;
                n_state = S_MUL;
            end

            S_F_SXX: begin
                n_cxx = cxx_c;
                if (cxx_c == '0) begin
                    // flat line: residuals are the y deviations
                    n_status = ST_CONST_X;
                    n_kind   = K_RSE;
                    n_s      = '0;
                    n_bit    = 5'd16;
                    n_sm     = WIDE_W'(r_kn2);
                    n_rhs    = WIDE_W'(r_a);
                    n_lim    = LIM_STD;
                    n_state  = S_SR_STEP;
                end else begin
                    n_status = ST_VALID;
                    n_ma     = WIDE_W'(abs_sxy);
                    n_mb     = DATA_W'(r_n);
                    n_acc    = '0;
                    n_ret    = S_F_NXY;
                    n_state  = S_MUL;
                end
            end

            S_F_NXY: begin
                n_t1    = cur_sxy[SXY_W-1] ? -$signed(r_acc[DATA_W-1:0])
                                           :  $signed(r_acc[DATA_W-1:0]);
                n_ma    = WIDE_W'(abs_sx);
                n_mb    = DATA_W'(abs_sy);
                n_acc   = '0;
                n_ret   = S_F_SXY;
                n_state = S_MUL;
            end

            S_F_SXY: begin
                n_mag   = cxy_c[DATA_W-1] ? DATA_W'(-cxy_c) : DATA_W'(cxy_c);
                n_ma    = WIDE_W'(r_a);
                n_mb    = r_cxx;
                n_acc   = '0;
                n_ret   = S_F_PROD;
                n_state = S_MUL;
            end

            S_F_PROD: begin
                n_prod  = r_acc;
                n_ma    = WIDE_W'(r_mag);
                n_mb    = r_mag;
                n_acc   = '0;
                n_ret   = S_F_C2;
                n_state = S_MUL;
            end

            S_F_C2: begin
                n_c2    = r_acc;
                n_ma    = WIDE_W'(r_cxx);
                n_mb    = DATA_W'(r_kn2);
                n_acc   = '0;
                n_ret   = S_F_KM;
                n_state = S_MUL;
            end

            S_F_KM: begin
                n_kind  = K_RSE;
                n_s     = '0;
                n_bit   = 5'd16;
                n_sm    = r_acc;
                n_rhs   = r_prod - r_c2;
                n_lim   = LIM_STD;
                n_state = S_SR_STEP;
            end

            S_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov       = 1'b1;
                    n_o_fi     = r_fi;
                    n_o_ystd   = (r_status == ST_CONST_Y) ? 16'd0 : r_ystd;
                    n_o_rse    = (r_status == ST_CONST_Y) ? 16'd0 : r_rse;
                    n_o_r2     = (r_status == ST_VALID) ? r_r2 : 17'd0;
                    n_o_corr   = (r_status == ST_VALID) ? r_corr : 17'd0;
                    n_o_status = r_status;
                    n_o_last   = is_last;
                    if (is_last) begin
                        // start over: skip again, then a fresh window
                        n_item_cnt = '0;
                        n_fill     = '0;
                        n_sum_y    = '0;
                        for (int f = 0; f < NF; f++) begin
                            n_sum_x[f]  = '0;
                            n_sum_xy[f] = '0;
                            n_sum_xx[f] = '0;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_fi    = r_fi + 2'd1;
                        n_state = S_F_INIT;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_start   <= WINDOW_START_RST;
            r_window_size    <= WINDOW_SIZE_RST;
            r_active_factors <= ACTIVE_FACTORS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_START:   r_window_start   <= i_cfg_data;
                CFG_WINDOW_SIZE:    r_window_size    <= i_cfg_data[10:0];
                CFG_ACTIVE_FACTORS: r_active_factors <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- control and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_cnt <= '0;
            r_fill     <= '0;
            r_sum_y    <= '0;
            for (int f = 0; f < NF; f++) begin
                r_sum_x[f]  <= '0;
                r_sum_xy[f] <= '0;
                r_sum_xx[f] <= '0;
            end
            r_ov <= 1'b0;
        end else begin
            r_item_cnt <= n_item_cnt;
            r_fill     <= n_fill;
            r_sum_y    <= n_sum_y;
            r_sum_x    <= n_sum_x;
            r_sum_xy   <= n_sum_xy;
            r_sum_xx   <= n_sum_xx;
            r_ov       <= n_ov;
        end
    end

    // ---------------------------------------------------------------- working registers
    always_ff @(posedge i_clk) begin
        r_y        <= n_y;
        r_x        <= n_x;
        r_mf       <= n_mf;
        r_mph      <= n_mph;
        r_n        <= n_n;
        r_pi       <= n_pi;
        r_ny       <= n_ny;
        r_sq       <= n_sq;
        r_ssd      <= n_ssd;
        r_dq       <= n_dq;
        r_drem     <= n_drem;
        r_dcnt     <= n_dcnt;
        r_a        <= n_a;
        r_kn1      <= n_kn1;
        r_kn2      <= n_kn2;
        r_fi       <= n_fi;
        r_t1       <= n_t1;
        r_cxx      <= n_cxx;
        r_mag      <= n_mag;
        r_prod     <= n_prod;
        r_c2       <= n_c2;
        r_ma       <= n_ma;
        r_mb       <= n_mb;
        r_acc      <= n_acc;
        r_kind     <= n_kind;
        r_s        <= n_s;
        r_bit      <= n_bit;
        r_sm       <= n_sm;
        r_rhs      <= n_rhs;
        r_lim      <= n_lim;
        r_ystd     <= n_ystd;
        r_rse      <= n_rse;
        r_r2       <= n_r2;
        r_corr     <= n_corr;
        r_status   <= n_status;
        r_o_fi     <= n_o_fi;
        r_o_ystd   <= n_o_ystd;
        r_o_rse    <= n_o_rse;
        r_o_r2     <= n_o_r2;
        r_o_corr   <= n_o_corr;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

    assign o_out_valid          = r_ov;
    assign o_factor_index       = r_o_fi;
    assign o_y_std_dev          = r_o_ystd;
    assign o_residual_std_error = r_o_rse;
    assign o_r_squared          = r_o_r2;
    assign o_correlation        = r_o_corr;
    assign o_fit_status         = r_o_status;
    assign o_last_result        = r_o_last;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the windowed linear regression unit.
module testbench;
    import wlr_pkg::*;

    // ---------------------------------------------------------------- types
    typedef struct packed {
        logic [1:0]  factor_index;
        logic [15:0] y_std_dev;
        logic [15:0] residual_std_error;
        logic [16:0] r_squared;
        logic [16:0] correlation;
        logic [1:0]  fit_status;
        logic        last_result;
    } fit_result_t;

    // one directed transaction; fill_const_y marks a row that closes a window
    // whose y is constant, so every result of that window is known by eye
    typedef struct packed {
        logic [15:0] y;
        logic [15:0] x0;
        logic [15:0] x1;
        logic [15:0] x2;
        logic [15:0] x3;
        logic        fill_const_y;
    } stim_row_t;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES = 60;  // longer than the accumulate phase of a stored sample

    // windows of three, four factors, after reset
    localparam stim_row_t DIR_TAB [12] = '{
        // constant y at zero, x at its extremes
        '{16'h0000, 16'h8000, 16'h7fff, 16'h0000, 16'h0001, 1'b0},
        '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h0001, 1'b0},
        '{16'h0000, 16'h0000, 16'h0001, 16'h0002, 16'h8000, 1'b1},
        // y at its extremes: x0 constant, x1 = y, x2 opposed, x3 mixed
        '{16'h7fff, 16'h0005, 16'h7fff, 16'h8000, 16'h1234, 1'b0},
        '{16'h8000, 16'h0005, 16'h8000, 16'h7fff, 16'hedcb, 1'b0},
        '{16'h0000, 16'h0005, 16'h0000, 16'h0000, 16'h5555, 1'b0},
        // constant y at its maximum
        '{16'h7fff, 16'h0001, 16'h7fff, 16'h8000, 16'haaaa, 1'b0},
        '{16'h7fff, 16'h0100, 16'h0000, 16'h7fff, 16'h5555, 1'b0},
        '{16'h7fff, 16'h8000, 16'h0002, 16'h0003, 16'hffff, 1'b1},
        // both y and x constant at the minimum: constant y takes precedence
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0},
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0},
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1}
    };

    // ---------------------------------------------------------------- DUT signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_WINDOW_START;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic signed [SAMPLE_W-1:0] i_y_sample = '0;
    logic signed [SAMPLE_W-1:0] i_x_sample_0 = '0;
    logic signed [SAMPLE_W-1:0] i_x_sample_1 = '0;
    logic signed [SAMPLE_W-1:0] i_x_sample_2 = '0;
    logic signed [SAMPLE_W-1:0] i_x_sample_3 = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_factor_index;
    logic [15:0] o_y_std_dev;
    logic [15:0] o_residual_std_error;
    logic [16:0] o_r_squared;
    logic [16:0] o_correlation;
    logic [1:0]  o_fit_status;
    logic        o_last_result;

    windowed_linear_regression_unit u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- bench state
    fit_result_t pending_fits [$];
    int unsigned fail_count   = 0;
    int unsigned items_sent   = 0;
    int unsigned fits_checked = 0;
    int unsigned settings_run = 0;
    int unsigned idle_pct     = 0;
    int unsigned stall_pct    = 0;
    int unsigned cycle_count  = 0;

    // mirror of the block's registers and window state
    int unsigned        win_start, win_size, win_factors;
    int unsigned        skip_count, fill_count;
    logic signed [15:0] y_hist [1024];
    logic signed [15:0] x_hist [1024][4];
    longint             sum_y;
    longint             sum_x [4];
    longint             sum_xy [4];
    longint             sum_xx [4];

    // ---------------------------------------------------------------- predictor
    // largest s <= lim with s*s*k*m <= rhs, in 128-bit modular arithmetic
    function automatic logic [16:0] root_below(logic [16:0] lim, logic [127:0] k,
                                               logic [127:0] m, logic [127:0] rhs);
        logic [16:0]  s;
        logic [16:0]  c;
        logic [127:0] p;
        s = '0;
        for (int b = 16; b >= 0; b--) begin
            c = s | (17'd1 << b);
            p = c * c * k * m;
            if (c <= lim && p <= rhs)
                s = c;
        end
        return s;
    endfunction

    function automatic void clear_window();
        skip_count = 0;
        fill_count = 0;
        sum_y      = 0;
        for (int f = 0; f < 4; f++) begin
            sum_x[f]  = 0;
            sum_xy[f] = 0;
            sum_xx[f] = 0;
        end
    endfunction

    // take one accepted sample; a closing sample queues one fit per active factor
    function automatic void fit_item(logic signed [15:0] y, logic signed [15:0] xv [4]);
        longint       n, d;
        logic [63:0]  dev_sum, a, ux, uy, cxx, cxy, mag, mm;
        logic [127:0] prod, c2, c2s, trial;
        logic [16:0]  r2v, c;
        int           nf;
        fit_result_t  r;
        if (fill_count == 0 && skip_count < win_start) begin
            skip_count++;
            return;
        end
        n = (win_size < 3) ? 3 : (win_size > 1024) ? 1024 : win_size;
        y_hist[fill_count] = y;
        sum_y += y;
        for (int f = 0; f < 4; f++) begin
            x_hist[fill_count][f] = xv[f];
            sum_x[f]  += xv[f];
            sum_xy[f] += longint'(xv[f]) * y;
            sum_xx[f] += longint'(xv[f]) * xv[f];
        end
        fill_count++;
        if (fill_count < n)
            return;

        // second pass: n*SST from deviations of n*y against the sum
        n = fill_count;
        dev_sum = '0;
        for (int i = 0; i < n; i++) begin
            d = n * y_hist[i] - sum_y;
            mm = (d < 0) ? -d : d;
            dev_sum += mm * mm;
        end
        a = dev_sum / n;
        nf = (win_factors < 1) ? 1 : (win_factors > 4) ? 4 : win_factors;

        for (int f = 0; f < nf; f++) begin
            ux  = sum_x[f];
            uy  = sum_y;
            cxx = n * sum_xx[f] - ux * ux;
            cxy = n * sum_xy[f] - ux * uy;
            mag = cxy[63] ? -cxy : cxy;
            r.factor_index       = 2'(f);
            r.y_std_dev          = '0;
            r.residual_std_error = '0;
            r.r_squared          = '0;
            r.correlation        = '0;
            r.last_result        = (f + 1 == nf);
            if (a == 0) begin
                r.fit_status = ST_CONST_Y;
            end else begin
                r.y_std_dev = 16'(root_below(LIM_STD, n * (n - 1), 1, a));
                if (cxx == 0) begin
                    r.fit_status         = ST_CONST_X;
                    r.residual_std_error = 16'(root_below(LIM_STD, n * (n - 2), 1, a));
                end else begin
                    prod = a * cxx;
                    c2   = mag * mag;
                    c2s  = c2 << 16;
                    r.fit_status         = ST_VALID;
                    r.residual_std_error = 16'(root_below(LIM_STD, n * (n - 2), cxx,
                                                          prod - c2));
                    r2v = '0;
                    for (int b = 16; b >= 0; b--) begin
                        c = r2v | (17'd1 << b);
                        trial = prod * c;
                        if (c <= LIM_Q16 && trial <= c2s)
                            r2v = c;
                    end
                    r.r_squared   = r2v;
                    r.correlation = root_below(LIM_Q16, 1, 1, {r2v, 16'd0});
                end
            end
            pending_fits = {pending_fits, r};
        end
        clear_window();
    endfunction

    // ---------------------------------------------------------------- drivers
    // all three registers in one burst; valid stays high between transactions
    task automatic program_regs(int unsigned start, int unsigned size, int unsigned factors);
        logic [15:0] val;
        for (int i = 0; i < 3; i++) begin
            case (i)
                0: begin i_cfg_index <= CFG_WINDOW_START;   val = 16'(start);   end
                1: begin i_cfg_index <= CFG_WINDOW_SIZE;    val = 16'(size);    end
                default: begin i_cfg_index <= CFG_ACTIVE_FACTORS; val = 16'(factors); end
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_data  <= val;
            @(negedge i_clk);
            while (!o_cfg_ready) @(negedge i_clk);
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        win_start   = start & 16'hffff;
        win_size    = size & 11'h7ff;
        win_factors = factors & 3'h7;
        settings_run++;
    endtask

    // one input transaction, with a random idle gap ahead of it
    task automatic push_item(logic signed [15:0] y, logic signed [15:0] xv [4]);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_y_sample   <= y;
        i_x_sample_0 <= xv[0];
        i_x_sample_1 <= xv[1];
        i_x_sample_2 <= xv[2];
        i_x_sample_3 <= xv[3];
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
        fit_item(y, xv);
    endtask

    // registers may only be touched once every fit is out and the sample path is quiet
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_fits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_sample(int unsigned mode);
        if (mode < 6)
            return 16'($signed($urandom_range(127)) - 64);  // narrow spread
        return 16'($urandom_range(65535));
    endfunction

    // random windows under one register setting; each window gets its own flavour
    task automatic run_phase(int unsigned start, int unsigned size, int unsigned factors,
                             int unsigned idle, int unsigned stall, int unsigned target);
        int unsigned        stored, mode, span;
        logic signed [15:0] cy, cx, y;
        logic signed [15:0] xv [4];
        program_regs(start, size, factors);
        idle_pct  = idle;
        stall_pct = stall;
        stored    = 0;
        // samples the block really stores per window
        span      = (size < 3) ? 3 : (size > 1024) ? 1024 : size;
        while (stored < target) begin
            mode = $urandom_range(9);       // 0: constant y, 1: constant x0
            cy   = 16'($urandom_range(65535));
            cx   = 16'($urandom_range(65535));
            for (int j = 0; j < start + span; j++) begin
                y = (mode == 0) ? cy : rand_sample(mode);
                for (int f = 0; f < 4; f++)
                    xv[f] = rand_sample(mode);
                if (mode == 1)
                    xv[0] = cx;
                push_item(y, xv);
                if (j >= start)
                    stored++;
            end
        end
        wait_drained();
    endtask

    // ---------------------------------------------------------------- result side
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    function automatic int field_bad(string name, logic [16:0] want, logic [16:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // sampled mid-cycle: values are settled and this transaction lands on the next edge
    always @(negedge i_clk) begin
        fit_result_t e;
        int          bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_fits.size() == 0) begin
                $error("result for factor %0d with no fit outstanding", o_factor_index);
                fail_count++;
            end else begin
                e = pending_fits.pop_front();
                bad = field_bad("factor_index", e.factor_index, o_factor_index)
                    + field_bad("y_std_dev", e.y_std_dev, o_y_std_dev)
                    + field_bad("residual_std_error", e.residual_std_error,
                                o_residual_std_error)
                    + field_bad("r_squared", e.r_squared, o_r_squared)
                    + field_bad("correlation", e.correlation, o_correlation)
                    + field_bad("fit_status", e.fit_status, o_fit_status)
                    + field_bad("last_result", e.last_result, o_last_result);
                if (bad != 0)
                    fail_count++;
                fits_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d fits outstanding",
                     cycle_count, pending_fits.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        logic signed [15:0] xv [4];
        int unsigned        base;
        win_start   = WINDOW_START_RST;
        win_size    = WINDOW_SIZE_RST;
        win_factors = ACTIVE_FACTORS_RST;
        clear_window();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: windows of three over four factors
        program_regs(0, 3, 4);
        foreach (DIR_TAB[i]) begin
            xv = '{DIR_TAB[i].x0, DIR_TAB[i].x1, DIR_TAB[i].x2, DIR_TAB[i].x3};
            base = pending_fits.size();
            push_item(DIR_TAB[i].y, xv);
            if (DIR_TAB[i].fill_const_y)
                for (int k = base; k < pending_fits.size(); k++) begin
                    pending_fits[k].y_std_dev          = '0;
                    pending_fits[k].residual_std_error = '0;
                    pending_fits[k].r_squared          = '0;
                    pending_fits[k].correlation        = '0;
                    pending_fits[k].fit_status         = ST_CONST_Y;
                end
        end
        wait_drained();

        // window shrunk below the stored count: next sample closes it with four
        program_regs(0, 5, 4);
        for (int i = 0; i < 3; i++) begin
            foreach (xv[f]) xv[f] = 16'($urandom_range(65535));
            push_item(16'($urandom_range(65535)), xv);
        end
        wait_drained();
        program_regs(0, 3, 2);
        foreach (xv[f]) xv[f] = 16'($urandom_range(65535));
        push_item(16'($urandom_range(65535)), xv);
        wait_drained();

        // random phases with each idling pattern
        run_phase(2, 4, 3, 0, 0, 24);
        run_phase(0, 3, 1, 84, 0, 27);
        run_phase(1, 7, 2, 0, 84, 28);
        run_phase(0, 5, 4, 16, 16, 40);
        // register extremes: window length clamped at its low end, factor count at both ends
        run_phase(0, 0, 7, 0, 0, 12);
        run_phase(0, 2, 0, 0, 0, 9);

        $display("%0d samples sent under %0d register settings, %0d fits checked",
                 items_sent, settings_run, fits_checked);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
